FILE: src/hbs_pkg.sv
// ----------------------------------------------------------------------------
// Heightfield bilinear sampler package
// Shared widths, codes and types of the sampler pipeline.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Item and register widths
  localparam int QUERY_W    = 32;
  localparam int HEIGHT_W   = 16;
  localparam int OUT_W      = 24;
  localparam int SIDE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Field geometry: 64 samples per side, spacing of 1024 subunits
  localparam int MAX_SIDE   = 64;
  localparam int IDX_W      = 6;
  localparam int HALF_W     = IDX_W - 1;
  localparam int FRAC_W     = 10;
  localparam int SPACING    = 1 << FRAC_W;
  localparam int POS_W      = IDX_W + FRAC_W;

  // Four banks split by row and column parity
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Blend arithmetic: weights sum to SPACING squared; 256 subunits per unit
  localparam int SUB_SHIFT  = 8;
  localparam int DIV_SHIFT  = 2 * FRAC_W - SUB_SHIFT;
  localparam int WEIGHT_W   = 2 * FRAC_W + 1;
  localparam int PROD_W     = HEIGHT_W + WEIGHT_W + 1;
  localparam int SUM_W      = PROD_W;
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << DIV_SHIFT) - 1);

  // Cycles from an accepted query to its result strobe
  localparam int PIPE_LATENCY = 6;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERRAIN_READY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_HEIGHT   = 2'd2;

  typedef logic [HEIGHT_W-1:0] sample_t;
  typedef sample_t [3:0] sample_quad_t;

  // Located query: base cell index, fraction and far-edge flag per axis
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  sx;
    logic [IDX_W-1:0]  sz;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic              ex;
    logic              ez;
  } locate_t;

endpackage

FILE: src/hbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered (read before write).
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/hbs_locate.sv
// ----------------------------------------------------------------------------
// Query locator
// Clamps a query position to the field and splits it into index and fraction.
// ----------------------------------------------------------------------------
module hbs_locate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        query_accept,
  input  logic [hbs_pkg::QUERY_W-1:0] query_x,
  input  logic [hbs_pkg::QUERY_W-1:0] query_z,
  input  logic [hbs_pkg::SIDE_W-1:0]  samples_per_side,
  output hbs_pkg::locate_t            loc_r
);

  logic [hbs_pkg::SIDE_W-1:0] side_clamped;
  logic [hbs_pkg::IDX_W-1:0]  last_idx;
  logic [hbs_pkg::POS_W-1:0]  edge_pos;
  logic [hbs_pkg::POS_W-1:0]  pos_x;
  logic [hbs_pkg::POS_W-1:0]  pos_z;
  hbs_pkg::locate_t           loc_nxt;

  function automatic logic [hbs_pkg::POS_W-1:0] clamp_pos(
    input logic [hbs_pkg::QUERY_W-1:0] v,
    input logic [hbs_pkg::POS_W-1:0]   lim
  );
    logic [hbs_pkg::POS_W-1:0] res;
    if (v[hbs_pkg::QUERY_W-1]) begin
      res = '0;
    end else if (v > hbs_pkg::QUERY_W'(lim)) begin
      res = lim;
    end else begin
      res = v[hbs_pkg::POS_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    if (samples_per_side < hbs_pkg::SIDE_W'(2)) begin
      side_clamped = hbs_pkg::SIDE_W'(2);
    end else if (samples_per_side > hbs_pkg::SIDE_W'(hbs_pkg::MAX_SIDE)) begin
      side_clamped = hbs_pkg::SIDE_W'(hbs_pkg::MAX_SIDE);
    end else begin
      side_clamped = samples_per_side;
    end
    last_idx = hbs_pkg::IDX_W'(side_clamped - hbs_pkg::SIDE_W'(1));
    edge_pos = {last_idx, {hbs_pkg::FRAC_W{1'b0}}};

    pos_x = clamp_pos(query_x, edge_pos);
    pos_z = clamp_pos(query_z, edge_pos);

    loc_nxt.valid = query_accept;
    loc_nxt.sx    = pos_x[hbs_pkg::POS_W-1:hbs_pkg::FRAC_W];
    loc_nxt.sz    = pos_z[hbs_pkg::POS_W-1:hbs_pkg::FRAC_W];
    loc_nxt.fx    = pos_x[hbs_pkg::FRAC_W-1:0];
    loc_nxt.fz    = pos_z[hbs_pkg::FRAC_W-1:0];
    // On the last sample the next neighbor repeats it.
    loc_nxt.ex    = (loc_nxt.sx == last_idx);
    loc_nxt.ez    = (loc_nxt.sz == last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r.valid <= 1'b0;
    end else begin
      loc_r <= loc_nxt;
    end
  end

endmodule

FILE: src/hbs_store.sv
// ----------------------------------------------------------------------------
// Height store
// Four parity banks so that one query reads its four neighbors in a single read.
// ----------------------------------------------------------------------------
module hbs_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [hbs_pkg::IDX_W-1:0]   wr_col,
  input  logic [hbs_pkg::IDX_W-1:0]   wr_row,
  input  hbs_pkg::sample_t            wr_value,
  input  hbs_pkg::locate_t            loc,
  output hbs_pkg::sample_quad_t       samples
);

  logic [hbs_pkg::IDX_W:0]    sx_inc;
  logic [hbs_pkg::IDX_W:0]    sz_inc;
  logic [hbs_pkg::HALF_W-1:0] col_half_even;
  logic [hbs_pkg::HALF_W-1:0] col_half_odd;
  logic [hbs_pkg::HALF_W-1:0] row_half_even;
  logic [hbs_pkg::HALF_W-1:0] row_half_odd;
  logic [1:0]                 wr_bank;
  logic [hbs_pkg::BANK_AW-1:0] wr_addr;
  hbs_pkg::sample_t           rd_data [4];
  logic                       px_r;
  logic                       pz_r;
  logic                       ex_r;
  logic                       ez_r;
  logic                       nxp;
  logic                       nzp;

  // The even bank holds the even one of (sx, sx + 1), the odd bank the odd one.
  // Past the last sample the even half wraps; that read is never selected.
  always_comb begin
    sx_inc        = {1'b0, loc.sx} + (hbs_pkg::IDX_W + 1)'(1);
    sz_inc        = {1'b0, loc.sz} + (hbs_pkg::IDX_W + 1)'(1);
    col_half_even = sx_inc[hbs_pkg::HALF_W:1];
    col_half_odd  = loc.sx[hbs_pkg::IDX_W-1:1];
    row_half_even = sz_inc[hbs_pkg::HALF_W:1];
    row_half_odd  = loc.sz[hbs_pkg::IDX_W-1:1];
    wr_bank       = {wr_row[0], wr_col[0]};
    wr_addr       = {wr_row[hbs_pkg::IDX_W-1:1], wr_col[hbs_pkg::IDX_W-1:1]};
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);
    logic [hbs_pkg::HALF_W-1:0]  rd_col;
    logic [hbs_pkg::HALF_W-1:0]  rd_row;
    logic [hbs_pkg::BANK_AW-1:0] rd_addr;

    assign rd_col  = BANK[0] ? col_half_odd : col_half_even;
    assign rd_row  = BANK[1] ? row_half_odd : row_half_even;
    assign rd_addr = {rd_row, rd_col};

    hbs_ram #(
      .WIDTH (hbs_pkg::HEIGHT_W),
      .DEPTH (hbs_pkg::BANK_DEPTH)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en && (wr_bank == BANK)),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data[b])
    );
  end

  always_ff @(posedge clk) begin
    px_r <= loc.sx[0];
    pz_r <= loc.sz[0];
    ex_r <= loc.ex;
    ez_r <= loc.ez;
  end

  always_comb begin
    nxp = ex_r ? px_r : ~px_r;
    nzp = ez_r ? pz_r : ~pz_r;
    samples[0] = rd_data[{pz_r, px_r}];
    samples[1] = rd_data[{pz_r, nxp}];
    samples[2] = rd_data[{nzp, px_r}];
    samples[3] = rd_data[{nzp, nxp}];
  end

endmodule

FILE: src/hbs_blend.sv
// ----------------------------------------------------------------------------
// Bilinear blend
// Weights, four sample products, an adder tree and the final scaling.
// ----------------------------------------------------------------------------
module hbs_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hbs_pkg::locate_t               loc,
  input  hbs_pkg::sample_quad_t          samples,
  input  logic                           terrain_ready,
  input  logic [hbs_pkg::HEIGHT_W-1:0]   offmap_height,
  output logic                           out_valid_r,
  output logic [hbs_pkg::OUT_W-1:0]      out_height_r
);

  logic [hbs_pkg::FRAC_W:0]          wx0;
  logic [hbs_pkg::FRAC_W:0]          wz0;
  logic [hbs_pkg::FRAC_W:0]          wx1;
  logic [hbs_pkg::FRAC_W:0]          wz1;
  logic [hbs_pkg::WEIGHT_W-1:0]      w_nxt [4];
  logic [hbs_pkg::WEIGHT_W-1:0]      w_r   [4];
  logic signed [hbs_pkg::PROD_W-1:0] prod_nxt [4];
  logic signed [hbs_pkg::PROD_W-1:0] prod_r   [4];
  logic signed [hbs_pkg::SUM_W-1:0]  pair_r   [2];
  logic signed [hbs_pkg::SUM_W-1:0]  total_r;
  logic signed [hbs_pkg::SUM_W-1:0]  adj;
  logic signed [hbs_pkg::SUM_W-1:0]  quot;
  logic [hbs_pkg::OUT_W-1:0]         height_nxt;
  logic                              vw_r;
  logic                              vp_r;
  logic                              vs_r;
  logic                              vt_r;

  always_comb begin
    wx1 = {1'b0, loc.fx};
    wz1 = {1'b0, loc.fz};
    wx0 = (hbs_pkg::FRAC_W + 1)'(hbs_pkg::SPACING) - wx1;
    wz0 = (hbs_pkg::FRAC_W + 1)'(hbs_pkg::SPACING) - wz1;
    w_nxt[0] = hbs_pkg::WEIGHT_W'(wx0) * hbs_pkg::WEIGHT_W'(wz0);
    w_nxt[1] = hbs_pkg::WEIGHT_W'(wx1) * hbs_pkg::WEIGHT_W'(wz0);
    w_nxt[2] = hbs_pkg::WEIGHT_W'(wx0) * hbs_pkg::WEIGHT_W'(wz1);
    w_nxt[3] = hbs_pkg::WEIGHT_W'(wx1) * hbs_pkg::WEIGHT_W'(wz1);
  end

  // Samples arrive from the banks in the same cycle as the weights.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = hbs_pkg::PROD_W'($signed(samples[i]))
                  * hbs_pkg::PROD_W'($signed({1'b0, w_r[i]}));
    end
  end

  // Dividing by spacing squared and scaling to subunits is one shift;
  // negative sums are biased first so the shift truncates toward zero.
  always_comb begin
    adj  = total_r + (total_r[hbs_pkg::SUM_W-1] ? $signed(hbs_pkg::ROUND_BIAS)
                                                 : hbs_pkg::SUM_W'(0));
    quot = adj >>> hbs_pkg::DIV_SHIFT;
    if (terrain_ready) begin
      height_nxt = quot[hbs_pkg::OUT_W-1:0];
    end else begin
      height_nxt = {offmap_height, {hbs_pkg::SUB_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r        <= 1'b0;
      vp_r        <= 1'b0;
      vs_r        <= 1'b0;
      vt_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vw_r        <= loc.valid;
      vp_r        <= vw_r;
      vs_r        <= vp_r;
      vt_r        <= vs_r;
      out_valid_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    prod_r       <= prod_nxt;
    pair_r[0]    <= prod_r[0] + prod_r[1];
    pair_r[1]    <= prod_r[2] + prod_r[3];
    total_r      <= pair_r[0] + pair_r[1];
    out_height_r <= height_nxt;
  end

endmodule

FILE: src/heightfield_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// Heightfield bilinear sampler
// Loads a 64 x 64 field of signed heights and answers bilinear height queries.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at every rising edge with start high and busy low. With
//   in_opcode at write it stores in_sample_value at (in_sample_col,
//   in_sample_row) and gives no result. With in_opcode at query it clamps
//   (in_query_x, in_query_z) to the field, blends the four neighboring samples
//   and returns the height in subunits on out_ground_height, marked by a
//   one-cycle out_valid strobe. One word is taken every cycle while busy is
//   low. The store is four parity banks, so the four neighbors come out of
//   one read; a write is seen by every query taken after it.
//   The configuration registers (terrain ready, samples per side and the
//   off-map height) are written through cfg_we, cfg_index and cfg_data, by
//   the user only while no query is in flight (not enforced by the block).
//   With terrain ready low a query returns the off-map height times 256.
//   Reset sets the registers to their defaults and holds busy high for its
//   duration; the heightfield is not cleared and must be loaded before use.
//   The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [hbs_pkg::IDX_W-1:0]      in_sample_col,
  input  logic [hbs_pkg::IDX_W-1:0]      in_sample_row,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] in_sample_value,
  input  logic signed [hbs_pkg::QUERY_W-1:0]  in_query_x,
  input  logic signed [hbs_pkg::QUERY_W-1:0]  in_query_z,
  output logic                           out_valid,
  output logic signed [hbs_pkg::OUT_W-1:0]    out_ground_height,
  input  logic                           cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                          busy_r;
  logic                          terrain_ready_r;
  logic [hbs_pkg::SIDE_W-1:0]    samples_per_side_r;
  logic [hbs_pkg::HEIGHT_W-1:0]  offmap_height_r;
  logic                          accept;
  logic                          query_accept;
  logic                          write_accept;
  hbs_pkg::locate_t              loc;
  hbs_pkg::sample_quad_t         samples;
  logic                          blend_valid;
  logic [hbs_pkg::OUT_W-1:0]     blend_height;

  assign busy         = busy_r;
  assign accept       = start && !busy_r;
  assign query_accept = accept && (in_opcode == hbs_pkg::OP_QUERY);
  assign write_accept = accept && (in_opcode == hbs_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terrain_ready_r    <= 1'b0;
      samples_per_side_r <= hbs_pkg::SIDE_W'(hbs_pkg::MAX_SIDE);
      offmap_height_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbs_pkg::REG_TERRAIN_READY:    terrain_ready_r    <= cfg_data[0];
        hbs_pkg::REG_SAMPLES_PER_SIDE: samples_per_side_r <= cfg_data[hbs_pkg::SIDE_W-1:0];
        hbs_pkg::REG_OUTSIDE_HEIGHT:   offmap_height_r    <= cfg_data[hbs_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  hbs_locate u_locate (
    .clk              (clk),
    .rst_n            (rst_n),
    .query_accept     (query_accept),
    .query_x          (in_query_x),
    .query_z          (in_query_z),
    .samples_per_side (samples_per_side_r),
    .loc_r            (loc)
  );

  // Stored samples are as wide as the input word, so no saturation is needed.
  hbs_store u_store (
    .clk      (clk),
    .wr_en    (write_accept),
    .wr_col   (in_sample_col),
    .wr_row   (in_sample_row),
    .wr_value (in_sample_value),
    .loc      (loc),
    .samples  (samples)
  );

  hbs_blend u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .loc            (loc),
    .samples        (samples),
    .terrain_ready  (terrain_ready_r),
    .offmap_height  (offmap_height_r),
    .out_valid_r    (blend_valid),
    .out_height_r   (blend_height)
  );

  assign out_valid         = blend_valid;
  assign out_ground_height = blend_height;

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(query_accept, hbs_pkg::PIPE_LATENCY))
    else $error("result strobe without a query taken");

  a_no_result_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(write_accept, hbs_pkg::PIPE_LATENCY) |-> !out_valid)
    else $error("result strobe for a write word");

  a_offmap_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !terrain_ready_r |->
      out_ground_height == {offmap_height_r, {hbs_pkg::SUB_SHIFT{1'b0}}})
    else $error("off-map height answer mismatch");

endmodule
